[sv/sac_pkg.sv]
// ----------------------------------------------------------------------------
// sac_pkg
// Shared widths, codes and controller/datapath handshake types for the
// segment allocation checker.
// ----------------------------------------------------------------------------
package sac_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // field widths
  localparam int MODE_W   = 2;
  localparam int BASE_W   = 20;
  localparam int LEN_W    = 14;
  localparam int END_W    = 21;
  localparam int STATUS_W = 3;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_MEM_LIMIT = CFG_ADDR_W'(0);
  localparam logic [END_W-1:0] MEM_LIMIT_RST = END_W'(1048576);

  // request modes
  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_ACCESS  = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  // result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_OVER_LIMIT = 3'd1,
    ST_OVERLAP    = 3'd2,
    ST_FULL       = 3'd3,
    ST_DENIED     = 3'd4,
    ST_RELEASED   = 3'd5
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic latch;   // capture the accepted word
    logic commit;  // apply table update and load the result register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;  // result register holds a word that is stalled
  } dp_stat_t;

endpackage

[sv/segment_allocation_checker_core.sv]
// ----------------------------------------------------------------------------
// segment_allocation_checker_core
// Range table of one process answering allocate, access and release requests.
//
//   channel   dir  handshake                 payload
//   in_       in   in_valid / in_stall       in_mode, in_region_base,
//                                            in_region_length
//   out_      out  out_valid / out_stall     out_status
//   cfg       in   psel/penable/pwrite/pready paddr, pwdata, prdata
//
// Each word passes through a capture state and an evaluate state in which
// all sixteen entries are compared at once and the table is updated.
// A stalled result holds the evaluate state until the result register frees.
// Synchronous active-low reset empties the table and sets mem_limit to 2^20.
// ----------------------------------------------------------------------------
module segment_allocation_checker_core
  import sac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [MODE_W-1:0]     in_mode,
  input  logic [BASE_W-1:0]     in_region_base,
  input  logic [LEN_W-1:0]      in_region_length,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   out_status,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic             cfg_we;
  logic [END_W-1:0] mem_limit;

  // register port decode
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == REG_MEM_LIMIT);
  assign prdata = (paddr == REG_MEM_LIMIT) ? CFG_DATA_W'(mem_limit) : '0;

  sac_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  sac_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_mode          (in_mode),
    .in_region_base   (in_region_base),
    .in_region_length (in_region_length),
    .cfg_we           (cfg_we),
    .cfg_wdata        (pwdata[END_W-1:0]),
    .mem_limit        (mem_limit),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status)
  );

endmodule

[sv/sac_ctrl.sv]
// ----------------------------------------------------------------------------
// sac_ctrl
// Two-state sequencer: take a request word, then evaluate and commit it
// once the result register can take the answer.
// ----------------------------------------------------------------------------
module sac_ctrl
  import sac_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EVAL = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // handshake and commands
  always_comb begin
    in_stall   = (state_r != S_IDLE);
    cmd.latch  = (state_r == S_IDLE) && in_valid;
    cmd.commit = (state_r == S_EVAL) && !stat.out_busy;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (!stat.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/sac_dp.sv]
// ----------------------------------------------------------------------------
// sac_dp
// Range table, parallel overlap and cover compares, limit register and the
// result register.
// ----------------------------------------------------------------------------
module sac_dp
  import sac_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [BASE_W-1:0]   in_region_base,
  input  logic [LEN_W-1:0]    in_region_length,
  input  logic                cfg_we,
  input  logic [END_W-1:0]    cfg_wdata,
  output logic [END_W-1:0]    mem_limit,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status
);

  logic [END_W-1:0]  mem_limit_r;
  logic [MODE_W-1:0] req_mode_r;
  logic [BASE_W-1:0] req_base_r;
  logic [END_W-1:0]  req_end_r;

  logic [BASE_W-1:0]      rng_start_r [TABLE_DEPTH];
  logic [END_W-1:0]       rng_end_r   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] rng_valid_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;

  logic [TABLE_DEPTH-1:0] clash_v;
  logic [TABLE_DEPTH-1:0] hit_v;
  logic [IDX_W-1:0]       free_idx;
  logic                   over_limit;
  logic                   table_full;
  status_t                res_status;

  assign mem_limit     = mem_limit_r;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign stat.out_busy = out_valid_r && out_stall;

  // limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_limit_r <= MEM_LIMIT_RST;
    end else if (cfg_we) begin
      mem_limit_r <= cfg_wdata;
    end
  end

  // request capture, end computed exactly in 21 bits
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_mode_r <= in_mode;
      req_base_r <= in_region_base;
      req_end_r  <= END_W'(in_region_base) + END_W'(in_region_length);
    end
  end

  // per-entry compares
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      clash_v[i] = rng_valid_r[i] &&
                   (((rng_start_r[i] <= req_base_r) &&
                     (END_W'(req_base_r) <= rng_end_r[i])) ||
                    ((req_base_r < rng_start_r[i]) &&
                     (END_W'(rng_start_r[i]) < req_end_r)));
      hit_v[i]   = rng_valid_r[i] && (rng_start_r[i] <= req_base_r) &&
                   (END_W'(req_base_r) < rng_end_r[i]) &&
                   (req_end_r <= rng_end_r[i]);
    end
  end

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!rng_valid_r[i]) free_idx = IDX_W'(i);
    end
  end

  assign over_limit = (req_end_r > mem_limit_r);
  assign table_full = &rng_valid_r;

  // result code
  always_comb begin
    case (mode_t'(req_mode_r))
      MODE_ALLOC: begin
        if (over_limit)      res_status = ST_OVER_LIMIT;
        else if (|clash_v)   res_status = ST_OVERLAP;
        else if (table_full) res_status = ST_FULL;
        else                 res_status = ST_OK;
      end
      MODE_ACCESS:  res_status = (|hit_v) ? ST_OK : ST_DENIED;
      MODE_RELEASE: res_status = ST_RELEASED;
      default:      res_status = ST_DENIED;
    endcase
  end

  // valid bits: set on a granted allocate, cleared on refusal or release
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rng_valid_r <= '0;
    end else if (cmd.commit) begin
      if (mode_t'(req_mode_r) == MODE_ALLOC) begin
        if (res_status == ST_OK) rng_valid_r[free_idx] <= 1'b1;
        else                     rng_valid_r <= '0;
      end else if (mode_t'(req_mode_r) == MODE_RELEASE) begin
        rng_valid_r <= '0;
      end
    end
  end

  // range payload
  always_ff @(posedge clk) begin
    if (cmd.commit && (mode_t'(req_mode_r) == MODE_ALLOC) && (res_status == ST_OK)) begin
      rng_start_r[free_idx] <= req_base_r;
      rng_end_r[free_idx]   <= req_end_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= res_status;
    end
  end

endmodule

[sv/sac_checker.sv]
// ----------------------------------------------------------------------------
// sac_checker
// Port-level checks on request sequencing and result codes.
// ----------------------------------------------------------------------------
module sac_checker
  import sac_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic [MODE_W-1:0]   in_mode,
  input logic                out_valid,
  input logic                out_stall,
  input logic [STATUS_W-1:0] out_status
);

  // one word in flight: busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken while previous one still in flight");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status)))
    else $error("stalled result changed");

  // release answers released when the output is free
  a_release_code: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_mode == MODE_RELEASE) && !out_valid)
      |-> ##2 (out_valid && (out_status == ST_RELEASED)))
    else $error("release did not answer released");

  // unused mode is denied
  a_unused_code: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_mode == MODE_UNUSED) && !out_valid)
      |-> ##2 (out_valid && (out_status == ST_DENIED)))
    else $error("unused mode not denied");

endmodule

bind segment_allocation_checker_core sac_checker u_sac_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .in_mode    (in_mode),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_status (out_status)
);
